// ===== sv/mfbp_pkg.sv =====
`default_nettype none
package mfbp_pkg;

  localparam int unsigned CAPACITY_BYTES_DEF = 65536;
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [4:0] MAX_CODE_LEN = 5'd24;

  localparam logic [1:0] ACT_PUT_BITS = 2'd0;
  localparam logic [1:0] ACT_PUT_BYTE = 2'd1;
  localparam logic [1:0] ACT_FLUSH    = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LEN_LARGE = 2'd1;
  localparam logic [1:0] ST_UNALIGNED = 2'd2;
  localparam logic [1:0] ST_CAP_WARN  = 2'd3;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  count;
    logic                        byte_valid;
    logic [1:0]                  status;
    logic [19:0]                 total_bits;
    logic [16:0]                 total_bytes;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/mfbp_pack.sv =====
`default_nettype none
module mfbp_pack #(
  parameter int unsigned CAPACITY_BYTES = mfbp_pkg::CAPACITY_BYTES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [1:0]    action,
  input  wire logic [22:0]   code_value,
  input  wire logic [4:0]    code_length,
  output mfbp_pkg::res_t     res
);

  localparam logic [20:0] MarginLim = 21'(CAPACITY_BYTES - 4);

  logic [6:0]  pb_r, pb_nxt;
  logic [2:0]  pc_r, pc_nxt;
  logic [16:0] bc_r, bc_nxt;

  logic        margin;
  logic [29:0] acc;
  logic [29:0] code_mask;
  logic [4:0]  tot;
  logic [1:0]  nbytes;
  logic [7:0]  low_mask;
  logic [2:0]  pad_sh;
  logic [7:0]  flush_byte;

  assign margin     = {4'b0, bc_r} > MarginLim;
  assign code_mask  = (30'd1 << code_length) - 30'd1;
  assign acc        = ({23'b0, pb_r} << code_length) | ({7'b0, code_value} & code_mask);
  assign tot        = {2'b0, pc_r} + code_length;
  assign nbytes     = tot[4:3];
  assign low_mask   = (8'd1 << tot[2:0]) - 8'd1;
  assign pad_sh     = 3'(4'd8 - {1'b0, pc_r});
  assign flush_byte = {1'b0, pb_r} << pad_sh;

  always_comb begin
    pb_nxt         = pb_r;
    pc_nxt         = pc_r;
    bc_nxt         = bc_r;
    res.bytes      = '0;
    res.count      = 2'd1;
    res.byte_valid = 1'b0;
    res.status     = mfbp_pkg::ST_OK;
    unique case (action)
      mfbp_pkg::ACT_PUT_BITS: begin
        if (code_length >= mfbp_pkg::MAX_CODE_LEN) begin
          res.status = mfbp_pkg::ST_LEN_LARGE;
        end else begin
          res.status = margin ? mfbp_pkg::ST_CAP_WARN : mfbp_pkg::ST_OK;
          for (int i = 0; i < mfbp_pkg::MAX_RESULTS; i++) begin
            if (2'(i) < nbytes) begin
              res.bytes[i] = 8'(acc >> (tot - 5'(8 * (i + 1))));
            end
          end
          if (nbytes != 2'd0) begin
            res.count      = nbytes;
            res.byte_valid = 1'b1;
          end
          pc_nxt = tot[2:0];
          pb_nxt = acc[6:0] & low_mask[6:0];
          bc_nxt = bc_r + 17'(nbytes);
        end
      end
      mfbp_pkg::ACT_PUT_BYTE: begin
        if (pc_r != 3'd0) begin
          res.status = mfbp_pkg::ST_UNALIGNED;
        end else begin
          res.status     = margin ? mfbp_pkg::ST_CAP_WARN : mfbp_pkg::ST_OK;
          res.bytes[0]   = code_value[7:0];
          res.byte_valid = 1'b1;
          bc_nxt         = bc_r + 17'd1;
        end
      end
      mfbp_pkg::ACT_FLUSH: begin
        if (pc_r != 3'd0) begin
          res.bytes[0]   = flush_byte;
          res.byte_valid = 1'b1;
          bc_nxt         = bc_r + 17'd1;
          pb_nxt         = '0;
          pc_nxt         = '0;
        end
      end
      default: begin
      end
    endcase
    res.total_bits  = {bc_nxt, pc_nxt};
    res.total_bytes = bc_nxt + {16'b0, (pc_nxt != 3'd0)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r <= '0;
      pc_r <= '0;
      bc_r <= '0;
    end else if (accept) begin
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
      bc_r <= bc_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mfbp_ser.sv =====
`default_nettype none
module mfbp_ser (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire mfbp_pkg::res_t res,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_last_result,
  output logic [1:0]          out_status,
  output logic [19:0]         out_total_bits,
  output logic [16:0]         out_total_bytes
);

  mfbp_pkg::res_t res_r;
  logic           full_r;
  logic [1:0]     idx_r;
  logic           last;
  logic           pop;
  logic           load;

  assign last     = idx_r == (res_r.count - 2'd1);
  assign pop      = full_r && out_ready;
  assign in_ready = !full_r || (pop && last);
  assign load     = in_valid && in_ready;

  assign out_valid       = full_r;
  assign out_byte        = (idx_r < 2'(mfbp_pkg::MAX_RESULTS)) ? res_r.bytes[idx_r] : 8'd0;
  assign out_byte_valid  = res_r.byte_valid;
  assign out_last_result = last;
  assign out_status      = res_r.status;
  assign out_total_bits  = res_r.total_bits;
  assign out_total_bytes = res_r.total_bytes;

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      full_r <= 1'b1;
      idx_r  <= '0;
    end else if (pop) begin
      if (last) begin
        full_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/msb_first_bit_packer_unit.sv =====
// channel  direction  handshake             beat payload
// in       input      in_valid / in_ready   in_action, in_code_value, in_code_length
// out      output     out_valid / out_ready out_byte, out_byte_valid, out_last_result,
//                                           out_status, out_total_bits, out_total_bytes
//
// An item is packed in the cycle it is accepted; its one to three result beats are then
// held in the single result register and leave one per cycle while out_ready is high, so
// a new item is not taken before the last result beat of the current item is taken.
// in_ready rises again in the cycle the last result beat of the item is taken.
// Synchronous active-low reset clears the pending bits, bit count and byte count.
// Stalls on out_ready hold the result register and the packer state.
`default_nettype none
module msb_first_bit_packer_unit #(
  parameter int unsigned CAPACITY_BYTES = mfbp_pkg::CAPACITY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [22:0] in_code_value,
  input  wire logic [4:0]  in_code_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_last_result,
  output logic [1:0]       out_status,
  output logic [19:0]      out_total_bits,
  output logic [16:0]      out_total_bytes
);

  mfbp_pkg::res_t res;
  logic           accept;

  assign accept = in_valid && in_ready;

  mfbp_pack #(
    .CAPACITY_BYTES(CAPACITY_BYTES)
  ) u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .action     (in_action),
    .code_value (in_code_value),
    .code_length(in_code_length),
    .res        (res)
  );

  mfbp_ser u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .res            (res),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_result(out_last_result),
    .out_status     (out_status),
    .out_total_bits (out_total_bits),
    .out_total_bytes(out_total_bytes)
  );

endmodule
`default_nettype wire

// ===== verif/tb_msb_first_bit_packer_unit.sv =====
module tb_msb_first_bit_packer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP_BYTES = mfbp_pkg::CAPACITY_BYTES_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct {
    logic [1:0]  act;
    logic [22:0] val;
    logic [4:0]  len;
    bit          calm;
  } code_t;

  typedef struct {
    logic [7:0]  byt;
    logic        bval;
    logic        last;
    logic [1:0]  st;
    logic [19:0] tbits;
    logic [16:0] tbytes;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_action = '0;
  logic [22:0] in_code_value = '0;
  logic [4:0]  in_code_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_last_result;
  logic [1:0]  out_status;
  logic [19:0] out_total_bits;
  logic [16:0] out_total_bytes;

  code_t code_q[$];
  beat_t beat_q[$];
  code_t cur;
  beat_t want;
  bit    calm = 1'b0;
  int    gap_left = 0;
  int    stall_left = 0;
  int    quiet = 0;
  int    errors = 0;
  int    n_codes = 0;
  int    n_beats = 0;

  logic [6:0]  pend_bits = '0;
  int          pend_cnt = 0;
  logic [16:0] bytes_done = '0;

  msb_first_bit_packer_unit #(
    .CAPACITY_BYTES(CAP_BYTES)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_code_value  (in_code_value),
    .in_code_length (in_code_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_last_result(out_last_result),
    .out_status     (out_status),
    .out_total_bits (out_total_bits),
    .out_total_bytes(out_total_bytes)
  );

  always #10 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic pack_code(input code_t c);
    logic [30:0] acc;
    logic [7:0]  byts [3];
    logic [1:0]  st;
    bit          over;
    int          tot;
    int          n;
    int          nres;
    beat_t       b;
    n = 0;
    st = mfbp_pkg::ST_OK;
    over = int'(bytes_done) > CAP_BYTES - 4;
    case (c.act)
      mfbp_pkg::ACT_PUT_BITS: begin
        if (c.len >= mfbp_pkg::MAX_CODE_LEN) begin
          st = mfbp_pkg::ST_LEN_LARGE;
        end else begin
          st = over ? mfbp_pkg::ST_CAP_WARN : mfbp_pkg::ST_OK;
          acc = (31'(pend_bits) << c.len) | (31'(c.val) & ((31'd1 << c.len) - 31'd1));
          tot = pend_cnt + int'(c.len);
          while (tot >= 8) begin
            tot -= 8;
            byts[n] = 8'(acc >> tot);
            n++;
            bytes_done++;
          end
          pend_cnt = tot;
          pend_bits = 7'(acc & ((31'd1 << tot) - 31'd1));
        end
      end
      mfbp_pkg::ACT_PUT_BYTE: begin
        if (pend_cnt != 0) begin
          st = mfbp_pkg::ST_UNALIGNED;
        end else begin
          st = over ? mfbp_pkg::ST_CAP_WARN : mfbp_pkg::ST_OK;
          byts[0] = c.val[7:0];
          n = 1;
          bytes_done++;
        end
      end
      mfbp_pkg::ACT_FLUSH: begin
        if (pend_cnt != 0) begin
          byts[0] = 8'(16'(pend_bits) << (8 - pend_cnt));
          n = 1;
          bytes_done++;
          pend_bits = '0;
          pend_cnt = 0;
        end
      end
      default: begin
      end
    endcase
    nres = (n == 0) ? 1 : n;
    for (int k = 0; k < nres; k++) begin
      b.byt = (k < n) ? byts[k] : 8'd0;
      b.bval = (k < n);
      b.last = (k == nres - 1);
      b.st = st;
      b.tbits = {bytes_done, 3'b000} + 20'(pend_cnt);
      b.tbytes = bytes_done + 17'(pend_cnt != 0);
      beat_q.push_back(b);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        pack_code(cur);
        n_codes++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (code_q.size() != 0) begin
          cur = code_q.pop_front();
          in_valid <= 1'b1;
          in_action <= cur.act;
          in_code_value <= cur.val;
          in_code_length <= cur.len;
          calm <= cur.calm;
          gap_left = cur.calm ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_beats++;
        if (beat_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat: byte %h valid %b last %b status %0d",
                                     out_byte, out_byte_valid, out_last_result, out_status);
        end else begin
          want = beat_q.pop_front();
          if (out_byte !== want.byt || out_byte_valid !== want.bval ||
              out_last_result !== want.last || out_status !== want.st ||
              out_total_bits !== want.tbits || out_total_bytes !== want.tbytes) begin
            errors++;
            if (errors <= 10) begin
              $display("beat %0d expected byte %h valid %b last %b status %0d bits %0d bytes %0d",
                       n_beats, want.byt, want.bval, want.last, want.st, want.tbits,
                       want.tbytes);
              $display("beat %0d actual   byte %h valid %b last %b status %0d bits %0d bytes %0d",
                       n_beats, out_byte, out_byte_valid, out_last_result, out_status,
                       out_total_bits, out_total_bytes);
            end
          end
        end
      end
      if (calm) begin
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
        out_ready <= (stall_left == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end else begin
      quiet = 0;
    end
  end

  task automatic add_code(input logic [1:0] act, input logic [22:0] val,
                          input logic [4:0] len, input bit quiet_run);
    code_t c;
    c.act = act;
    c.val = val;
    c.len = len;
    c.calm = quiet_run;
    code_q.push_back(c);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (code_q.size() != 0 || in_valid || beat_q.size() != 0);
  endtask

  task automatic add_random(input int count, input int calm_lo, input int calm_hi);
    int r;
    bit q;
    for (int i = 0; i < count; i++) begin
      q = (i >= calm_lo && i < calm_hi);
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_code(mfbp_pkg::ACT_PUT_BITS, 23'($urandom), 5'($urandom_range(0, 23)), q);
      end else if (r < 62) begin
        add_code(mfbp_pkg::ACT_PUT_BITS, 23'($urandom), 5'($urandom_range(24, 31)), q);
      end else if (r < 72) begin
        add_code(mfbp_pkg::ACT_FLUSH, 23'($urandom), 5'($urandom), q);
        repeat ($urandom_range(1, 3)) begin
          add_code(mfbp_pkg::ACT_PUT_BYTE, 23'($urandom), 5'($urandom), q);
        end
      end else if (r < 80) begin
        add_code(mfbp_pkg::ACT_PUT_BYTE, 23'($urandom), 5'($urandom), q);
      end else if (r < 92) begin
        add_code(mfbp_pkg::ACT_FLUSH, 23'($urandom), 5'($urandom), q);
      end else begin
        add_code(ACT_NONE, 23'($urandom), 5'($urandom), q);
      end
    end
  endtask

  initial begin
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h7fffff, 5'd0, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h7fffff, 5'd23, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h000000, 5'd1, 1'b0);
    add_code(mfbp_pkg::ACT_FLUSH, 23'h7fffff, 5'd31, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h7ffff5, 5'd3, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h7fffff, 5'd24, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h7fffff, 5'd31, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BYTE, 23'h0000ff, 5'd0, 1'b0);
    add_code(ACT_NONE, 23'h7fffff, 5'd31, 1'b0);
    add_code(mfbp_pkg::ACT_FLUSH, 23'h000000, 5'd0, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BYTE, 23'h7fffff, 5'd31, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BYTE, 23'h7fff00, 5'd0, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h00007f, 5'd7, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h555555, 5'd23, 1'b0);
    add_code(mfbp_pkg::ACT_FLUSH, 23'h000000, 5'd0, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h0000a5, 5'd8, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h012345, 5'd16, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h000000, 5'd5, 1'b0);
    add_code(mfbp_pkg::ACT_PUT_BITS, 23'h2aaaab, 5'd2, 1'b0);
    add_code(mfbp_pkg::ACT_FLUSH, 23'h7fffff, 5'd0, 1'b0);
    add_code(ACT_NONE, 23'h000000, 5'd0, 1'b0);
    add_random(75, 30, 50);
    add_random(55, 0, 15);
    add_random(45, 20, 30);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();
    repeat (10) @(posedge clk);
    $display("%0d codes packed, %0d result beats checked", n_codes, n_beats);
    $display("mixed codes, raw bytes, flushes and oversized lengths under stalls; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
